>>> design/tvp_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity profile package
// Shared widths, register indexes and the payload types of both channels.
// ----------------------------------------------------------------------------
package tvp_pkg;

   localparam int CountBits = 16;
   localparam int CsrIdxBits = 1;

   localparam logic [CsrIdxBits-1:0] CSR_ACCEL_RATE = 1'd0;
   localparam logic [CsrIdxBits-1:0] CSR_TIME_STEP  = 1'd1;

   localparam logic [15:0] ACCEL_RESET = 16'd17920;
   localparam logic [15:0] STEP_RESET  = 16'd1311;

   typedef struct packed {
      logic        mode;
      logic [15:0] distance;
      logic [15:0] cruise_velocity;
   } req_type;

   typedef struct packed {
      logic [15:0] velocity;
      logic [15:0] point_index;
      logic        is_triangle;
      logic        is_last;
      logic        point_valid;
   } rsp_type;

   // Request to the shared serial unit and its answer.
   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [63:0] num;
      logic [47:0] den;
   } su_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } su_rsp_type;

   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

endpackage

>>> design/tvp_stream_if.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity profile stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface tvp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/trapezoid_velocity_profile_core.sv
// A tick runs two serial multiplies (a*t, then by the step); a tick with no profile
// running uses no serial operation.
// A start runs seven serial operations for a trapezoid; a triangle uses the square root and
// skips the hold division, and a zero cruise velocity skips the square root, a*t*v and hold division.
// One transaction at a time; the next is accepted the cycle after the result is taken.
// Reset (synchronous, active high) returns to idle with default register values.
// ----------------------------------------------------------------------------
// Trapezoid velocity profile core
// Plans a trapezoid or triangle move and gives one velocity point per tick.
// ----------------------------------------------------------------------------
module trapezoid_velocity_profile_core (
   input  logic                                clock,
   input  logic                                reset,
   tvp_stream_if.sink                          req,
   tvp_stream_if.source                        rsp,
   input  logic                                csr_write_enable,
   input  logic [tvp_pkg::CsrIdxBits-1:0]      csr_index,
   input  logic [15:0]                         csr_write_data
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_RAMP  = 3'd1;
   localparam logic [2:0] PH_HOLD  = 3'd2;
   localparam logic [2:0] PH_DECEL = 3'd3;

   localparam logic [3:0] S_WAIT  = 4'd0;
   localparam logic [3:0] S_AT    = 4'd1;  // a*t
   localparam logic [3:0] S_AD    = 4'd2;  // 16*a*d
   localparam logic [3:0] S_VV    = 4'd3;  // v*v
   localparam logic [3:0] S_SQ    = 4'd4;  // sqrt
   localparam logic [3:0] S_N     = 4'd5;  // ramp steps
   localparam logic [3:0] S_AV    = 4'd6;  // a*t*v
   localparam logic [3:0] S_H     = 4'd7;  // hold steps
   localparam logic [3:0] S_PK    = 4'd8;  // ramp value of N
   localparam logic [3:0] S_TICK  = 4'd9;  // ramp value of step
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_TAT   = 4'd11; // a*t for a tick

   localparam logic [tvp_pkg::CountBits-1:0] CountMax = '1;

   logic [15:0] accel_ff, tstep_ff;
   logic [3:0]  st_ff, st_in;
   logic [2:0]  phase_ff, phase_in;
   logic [tvp_pkg::CountBits-1:0] step_ff, step_in, ramp_ff, ramp_in, hold_ff, hold_in;
   logic [15:0] peak_ff, peak_in;
   logic        tri_ff, tri_in;
   logic [15:0] pcnt_ff, pcnt_in;
   logic [15:0] dist_ff, dist_in, vel_ff, vel_in;
   logic [31:0] at_ff, at_in;
   logic [47:0] ad_ff, ad_in;
   logic [31:0] vv_ff, vv_in;
   tvp_pkg::rsp_type out_ff, out_in;
   logic        ovalid_ff, ovalid_in;

   tvp_pkg::su_req_type su_req;
   tvp_pkg::su_rsp_type su_rsp;

   logic [15:0] a_eff, t_eff;
   logic [47:0] rv_sum;
   logic [15:0] rv_sat;
   logic [47:0] vpk_n;

   tvp_serial_unit u_su (.clock(clock), .reset(reset), .su_req(su_req), .su_rsp(su_rsp));

   assign a_eff = (accel_ff == 16'd0) ? 16'd1 : accel_ff;
   assign t_eff = (tstep_ff == 16'd0) ? 16'd1 : tstep_ff;

   // round and saturate a product a*t*i held in the unit result
   assign rv_sum = su_rsp.result[47:0] + 48'd32768;
   assign rv_sat = (rv_sum[47:32] != 16'd0) ? 16'hFFFF : rv_sum[31:16];

   assign req.ready = (st_ff == S_WAIT) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;

   function automatic logic [tvp_pkg::CountBits-1:0] sat_cnt(input logic [63:0] x);
      sat_cnt = (x > {{(64 - tvp_pkg::CountBits){1'b0}}, CountMax}) ? CountMax
                : x[tvp_pkg::CountBits-1:0];
   endfunction

   always_comb begin
      st_in    = st_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      ramp_in  = ramp_ff;
      hold_in  = hold_ff;
      peak_in  = peak_ff;
      tri_in   = tri_ff;
      pcnt_in  = pcnt_ff;
      dist_in  = dist_ff;
      vel_in   = vel_ff;
      at_in    = at_ff;
      ad_in    = ad_ff;
      vv_in    = vv_ff;
      out_in   = out_ff;
      ovalid_in = ovalid_ff;
      su_req   = '0;
      vpk_n    = '0;
      if (rsp.valid && rsp.ready) ovalid_in = 1'b0;
      case (st_ff)
         S_WAIT: begin
            if (req.valid && req.ready) begin
               if (!req.payload.mode) begin
                  dist_in = req.payload.distance;
                  vel_in  = req.payload.cruise_velocity;
                  su_req  = '{1'b1, tvp_pkg::OP_MUL, {48'd0, t_eff}, {32'd0, a_eff}};
                  st_in   = S_AT;
               end else if (phase_ff == PH_IDLE) begin
                  out_in = '0;
                  st_in  = S_OUT;
               end else begin
                  su_req = '{1'b1, tvp_pkg::OP_MUL, {48'd0, t_eff}, {32'd0, a_eff}};
                  st_in  = S_TAT;
               end
            end
         end
         S_TAT: if (su_rsp.done) begin
            at_in  = su_rsp.result[31:0];
            su_req = '{1'b1, tvp_pkg::OP_MUL,
                       {{(64 - tvp_pkg::CountBits){1'b0}}, step_ff},
                       {16'd0, su_rsp.result[31:0]}};
            st_in  = S_TICK;
         end
         S_AT: if (su_rsp.done) begin
            at_in  = su_rsp.result[31:0];
            su_req = '{1'b1, tvp_pkg::OP_MUL, {48'd0, dist_ff}, {28'd0, a_eff, 4'd0}};
            st_in  = S_AD;
         end
         S_AD: if (su_rsp.done) begin
            ad_in  = su_rsp.result[47:0];
            su_req = '{1'b1, tvp_pkg::OP_MUL, {48'd0, vel_ff}, {32'd0, vel_ff}};
            st_in  = S_VV;
         end
         S_VV: if (su_rsp.done) begin
            vv_in  = su_rsp.result[31:0];
            tri_in = ({16'd0, su_rsp.result[31:0]} > ad_ff);
            if ({16'd0, su_rsp.result[31:0]} > ad_ff) begin
               su_req = '{1'b1, tvp_pkg::OP_SQRT, {16'd0, ad_ff}, 48'd0};
               st_in  = S_SQ;
            end else begin
               su_req = '{1'b1, tvp_pkg::OP_DIV,
                          {32'd0, vel_ff, 16'd0} + {32'd0, at_ff} - 64'd1, {16'd0, at_ff}};
               st_in  = S_N;
            end
         end
         S_SQ: if (su_rsp.done) begin
            vpk_n  = {su_rsp.result[31:0], 16'd0};
            su_req = '{1'b1, tvp_pkg::OP_DIV,
                       {16'd0, vpk_n} + {32'd0, at_ff} - 64'd1, {16'd0, at_ff}};
            st_in  = S_N;
         end
         S_N: if (su_rsp.done) begin
            ramp_in = sat_cnt(su_rsp.result);
            if (tri_ff || vel_ff == 16'd0) begin
               hold_in = '0;
               su_req  = '{1'b1, tvp_pkg::OP_MUL,
                           {{(64 - tvp_pkg::CountBits){1'b0}}, sat_cnt(su_rsp.result)},
                           {16'd0, at_ff}};
               st_in   = S_PK;
            end else begin
               su_req = '{1'b1, tvp_pkg::OP_MUL, {48'd0, vel_ff}, {16'd0, at_ff}};
               st_in  = S_AV;
            end
         end
         S_AV: if (su_rsp.done) begin
            su_req = '{1'b1, tvp_pkg::OP_DIV, {(ad_ff - {16'd0, vv_ff}), 16'd0},
                       su_rsp.result[47:0]};
            st_in  = S_H;
         end
         S_H: if (su_rsp.done) begin
            hold_in = sat_cnt(su_rsp.result);
            su_req  = '{1'b1, tvp_pkg::OP_MUL,
                        {{(64 - tvp_pkg::CountBits){1'b0}}, ramp_ff}, {16'd0, at_ff}};
            st_in   = S_PK;
         end
         S_PK: if (su_rsp.done) begin
            peak_in  = tri_ff ? rv_sat : vel_ff;
            step_in  = '0;
            pcnt_in  = '0;
            phase_in = PH_RAMP;
            out_in   = '0;
            st_in    = S_OUT;
         end
         S_TICK: if (su_rsp.done) begin
            out_in.is_triangle = tri_ff;
            out_in.point_index = pcnt_ff;
            out_in.point_valid = 1'b1;
            out_in.is_last     = 1'b0;
            out_in.velocity    = 16'd0;
            pcnt_in = pcnt_ff + 16'd1;
            case (phase_ff)
               PH_RAMP: begin
                  out_in.velocity = rv_sat;
                  if (step_ff >= ramp_ff) begin
                     step_in  = '0;
                     phase_in = (hold_ff != '0) ? PH_HOLD : PH_DECEL;
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
               PH_HOLD: begin
                  out_in.velocity = peak_ff;
                  if (step_ff + 1'b1 >= hold_ff) begin
                     step_in  = '0;
                     phase_in = PH_DECEL;
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
               default: begin
                  if (step_ff < ramp_ff && rv_sat < peak_ff) begin
                     step_in = step_ff + 1'b1;
                     out_in.velocity = peak_ff - rv_sat;
                  end else begin
                     phase_in = PH_IDLE;
                     out_in.is_last = 1'b1;
                  end
               end
            endcase
            st_in = S_OUT;
         end
         S_OUT: begin
            ovalid_in = 1'b1;
            st_in     = S_WAIT;
         end
         default: st_in = S_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff  <= tvp_pkg::ACCEL_RESET;
         tstep_ff  <= tvp_pkg::STEP_RESET;
         st_ff     <= S_WAIT;
         phase_ff  <= PH_IDLE;
         step_ff   <= '0;
         ramp_ff   <= '0;
         hold_ff   <= '0;
         peak_ff   <= '0;
         tri_ff    <= 1'b0;
         pcnt_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == tvp_pkg::CSR_ACCEL_RATE)
            accel_ff <= csr_write_data;
         if (csr_write_enable && csr_index == tvp_pkg::CSR_TIME_STEP)
            tstep_ff <= csr_write_data;
         st_ff     <= st_in;
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         ramp_ff   <= ramp_in;
         hold_ff   <= hold_in;
         peak_ff   <= peak_in;
         tri_ff    <= tri_in;
         pcnt_ff   <= pcnt_in;
         ovalid_ff <= ovalid_in;
      end
      dist_ff <= dist_in;
      vel_ff  <= vel_in;
      at_ff   <= at_in;
      ad_ff   <= ad_in;
      vv_ff   <= vv_in;
      out_ff  <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset)
                    (req.valid && req.ready) |=> st_ff != S_WAIT)
      else $error("transaction accepted without work");
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("accepted while result pending");
   assert property (@(posedge clock) disable iff (reset) (st_ff == S_OUT) |=> rsp.valid)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == PH_HOLD && st_ff == S_WAIT) |-> !tri_ff)
      else $error("hold phase in triangle plan");

endmodule

>>> design/tvp_serial_unit.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity profile serial arithmetic unit
// Bit-serial multiply, restoring divide and square root, one bit per cycle.
// ----------------------------------------------------------------------------
module tvp_serial_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  tvp_pkg::su_req_type    su_req,
   output tvp_pkg::su_rsp_type    su_rsp
);

   logic        busy_ff, busy_in;
   logic [1:0]  op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;   // product / quotient / root
   logic [63:0] src_ff, src_in;   // multiplier bits / dividend / radicand
   logic [65:0] rem_ff, rem_in;   // remainder
   logic [47:0] den_ff, den_in;
   logic        done_ff, done_in;

   logic [65:0] trial;
   logic [65:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      trial   = '0;
      shifted = '0;
      if (su_req.start) begin
         busy_in = 1'b1;
         op_in   = su_req.op;
         acc_in  = '0;
         rem_in  = '0;
         src_in  = su_req.num;
         den_in  = su_req.den;
         cnt_in  = (su_req.op == tvp_pkg::OP_SQRT) ? 6'd31 : 6'd63;
      end else if (busy_ff) begin
         case (op_ff)
            tvp_pkg::OP_MUL: begin
               // shift-add, multiplier in src, multiplicand in den
               acc_in = {acc_ff[62:0], 1'b0} +
                        (src_ff[63] ? {16'd0, den_ff} : 64'd0);
               src_in = {src_ff[62:0], 1'b0};
            end
            tvp_pkg::OP_DIV: begin
               shifted = {rem_ff[64:0], src_ff[63]};
               trial   = shifted - {18'd0, den_ff};
               src_in  = {src_ff[62:0], 1'b0};
               if (!trial[65]) begin
                  rem_in = trial;
                  acc_in = {acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  acc_in = {acc_ff[62:0], 1'b0};
               end
            end
            tvp_pkg::OP_SQRT: begin
               shifted = {rem_ff[63:0], src_ff[63:62]};
               trial   = shifted - {acc_ff[63:0], 2'b01};
               src_in  = {src_ff[61:0], 2'b00};
               if (!trial[65]) begin
                  rem_in = trial;
                  acc_in = {acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  acc_in = {acc_ff[62:0], 1'b0};
               end
            end
            default: begin
               acc_in = '0;
            end
         endcase
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      src_ff <= src_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign su_rsp.done   = done_ff;
   assign su_rsp.result = acc_ff;

   assert property (@(posedge clock) disable iff (reset) su_rsp.done |-> !busy_ff)
      else $error("done while busy");
   assert property (@(posedge clock) disable iff (reset) su_req.start |=> busy_ff)
      else $error("start did not begin");
   assert property (@(posedge clock) disable iff (reset) su_rsp.done |-> $past(busy_ff))
      else $error("done without work");

endmodule

>>> bench/tvp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity profile checker
// Watches both channels and the register port, predicts each velocity point
// from its own model of the planner and compares every field in order.
// ----------------------------------------------------------------------------
module tvp_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  tvp_pkg::req_type               req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  tvp_pkg::rsp_type               rsp_payload,
   input  logic                           csr_write_enable,
   input  logic [tvp_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [15:0]                    csr_write_data,
   output int                             mismatches,
   output int                             points_pending,
   output int                             triangle_points,
   output int                             last_points
);

   typedef enum logic [2:0] {
      MOVE_IDLE, MOVE_RAMP, MOVE_HOLD, MOVE_DECEL
   } move_phase_type;

   localparam logic [63:0] CountMax = (64'd1 << tvp_pkg::CountBits) - 64'd1;

   logic [15:0]      accel_reg, step_reg;
   move_phase_type   move_phase;
   logic [63:0]      step_count, ramp_len, hold_len, peak_vel;
   logic             tri_plan;
   logic [15:0]      point_num;
   tvp_pkg::rsp_type expected_points[$];

   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root, trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   function automatic logic [63:0] ramp_point(input logic [63:0] i);
      logic [63:0] a, t, v;
      a = (accel_reg == 0) ? 64'd1 : 64'(accel_reg);
      t = (step_reg == 0) ? 64'd1 : 64'(step_reg);
      v = (a * t * i + 64'd32768) >> 16;
      return (v > 64'd65535) ? 64'd65535 : v;
   endfunction

   function automatic tvp_pkg::rsp_type make_point(input logic [63:0] vel,
                                                   input logic last);
      tvp_pkg::rsp_type r;
      r.velocity    = vel[15:0];
      r.point_index = point_num;
      r.is_triangle = tri_plan;
      r.is_last     = last;
      r.point_valid = 1'b1;
      point_num     = point_num + 16'd1;
      return r;
   endfunction

   function automatic tvp_pkg::rsp_type plan_or_tick(input tvp_pkg::req_type x);
      logic [63:0]      a, t, d, v, vpk, n, h, r;
      tvp_pkg::rsp_type p;
      a = (accel_reg == 0) ? 64'd1 : 64'(accel_reg);
      t = (step_reg == 0) ? 64'd1 : 64'(step_reg);
      p = '0;
      if (!x.mode) begin
         d = 64'(x.distance);
         v = 64'(x.cruise_velocity);
         tri_plan = (v * v > 64'd16 * a * d);
         vpk = tri_plan ? floor_sqrt(64'd16 * a * d) : v;
         n = (vpk * 64'd65536 + a * t - 64'd1) / (a * t);
         ramp_len = (n > CountMax) ? CountMax : n;
         if (tri_plan || v == 0) begin
            hold_len = '0;
         end else begin
            h = (64'd65536 * (64'd16 * a * d - v * v)) / (a * v * t);
            hold_len = (h > CountMax) ? CountMax : h;
         end
         peak_vel   = tri_plan ? ramp_point(ramp_len) : v;
         step_count = '0;
         point_num  = '0;
         move_phase = MOVE_RAMP;
         return p;
      end
      case (move_phase)
         MOVE_RAMP: begin
            r = ramp_point(step_count);
            if (step_count >= ramp_len) begin
               step_count = '0;
               move_phase = (hold_len != 0) ? MOVE_HOLD : MOVE_DECEL;
            end else begin
               step_count++;
            end
            p = make_point(r, 1'b0);
         end
         MOVE_HOLD: begin
            step_count++;
            if (step_count >= hold_len) begin
               step_count = '0;
               move_phase = MOVE_DECEL;
            end
            p = make_point(peak_vel, 1'b0);
         end
         MOVE_DECEL: begin
            r = ramp_point(step_count);
            if (step_count < ramp_len && r < peak_vel) begin
               step_count++;
               p = make_point(peak_vel - r, 1'b0);
            end else begin
               move_phase = MOVE_IDLE;
               p = make_point(64'd0, 1'b1);
            end
         end
         default: p = '0;
      endcase
      return p;
   endfunction

   always @(posedge clock) begin
      tvp_pkg::rsp_type want;
      if (reset) begin
         accel_reg       = tvp_pkg::ACCEL_RESET;
         step_reg        = tvp_pkg::STEP_RESET;
         move_phase      = MOVE_IDLE;
         step_count      = '0;
         ramp_len        = '0;
         hold_len        = '0;
         peak_vel        = '0;
         tri_plan        = 1'b0;
         point_num       = '0;
         mismatches      = 0;
         triangle_points = 0;
         last_points     = 0;
         expected_points.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected velocity point %p", rsp_payload);
            end else begin
               want = expected_points.pop_front();
               if (rsp_payload !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("point mismatch: expected %p, actual %p", want, rsp_payload);
               end
               if (rsp_payload.is_triangle && rsp_payload.point_valid) triangle_points++;
               if (rsp_payload.is_last) last_points++;
            end
         end
         if (req_valid && req_ready)
            expected_points.push_back(plan_or_tick(req_payload));
         if (csr_write_enable) begin
            if (csr_index == tvp_pkg::CSR_ACCEL_RATE) accel_reg = csr_write_data;
            else if (csr_index == tvp_pkg::CSR_TIME_STEP) step_reg = csr_write_data;
         end
      end
      points_pending = expected_points.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity profile core testbench
// Drives move plans and ticks under several register settings and idling
// patterns; the checker predicts and compares each velocity point.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CycleLimit = 5000000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [tvp_pkg::CsrIdxBits-1:0] csr_index = tvp_pkg::CSR_ACCEL_RATE;
   logic [15:0]                    csr_write_data = '0;
   int                    mismatches, points_pending, triangle_points, last_points;
   int                    cycles = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    hold_trigger = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    items_sent = 0;

   tvp_stream_if #(.payload_type(tvp_pkg::req_type)) req_ch ();
   tvp_stream_if #(.payload_type(tvp_pkg::rsp_type)) rsp_ch ();

   trapezoid_velocity_profile_core dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   tvp_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_payload(req_ch.payload),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_payload(rsp_ch.payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .mismatches(mismatches),
      .points_pending(points_pending),
      .triangle_points(triangle_points),
      .last_points(last_points)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("trapezoid_velocity_profile_core verification failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = 2000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input logic mode, input logic [15:0] distance_val,
                            input logic [15:0] vel);
      tvp_pkg::req_type x;
      x.mode            = mode;
      x.distance        = distance_val;
      x.cruise_velocity = vel;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= x;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tvp_pkg::CsrIdxBits-1:0] idx,
                            input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic ticks(input int n);
      for (int i = 0; i < n; i++)
         send_item(1'b1, 16'($urandom()), 16'($urandom()));
   endtask

   task automatic random_moves(input int n_items);
      int          goal;
      int          nt;
      logic [15:0] d, v;
      goal = items_sent + n_items;
      while (items_sent < goal) begin
         if ($urandom_range(0, 9) < 8) begin
            d = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 300));
            case ($urandom_range(0, 3))
               0: v = 16'($urandom());
               1: v = 16'($urandom_range(0, 255));
               default: v = 16'($urandom_range(0, 4000));
            endcase
            send_item(1'b0, d, v);
            nt = $urandom_range(1, 60);
            if (nt > goal - items_sent) nt = goal - items_sent;
            ticks(nt);
         end else begin
            send_item(1'($urandom()), 16'($urandom()), 16'($urandom()));
         end
      end
   endtask

   initial begin
      logic [15:0] accel_set[5];
      logic [15:0] step_set[5];
      int          idle_set[4];
      int          stall_set[4];
      accel_set = '{tvp_pkg::ACCEL_RESET, 16'd0, 16'd65535, 16'd1, 16'd4000};
      step_set  = '{tvp_pkg::STEP_RESET, 16'd0, 16'd65535, 16'd65535, 16'd700};
      idle_set  = '{0, 53, 0, 22};
      stall_set = '{0, 0, 53, 22};
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, idle ticks, triangle and trapezoid plans
      send_item(1'b1, 16'd0, 16'd0);
      send_item(1'b0, 16'd0, 16'd0);
      ticks(3);
      send_item(1'b0, 16'd65535, 16'd65535);
      ticks(4);
      send_item(1'b0, 16'd1, 16'd65535);
      ticks(6);
      send_item(1'b0, 16'd20, 16'd1500);
      ticks(8);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_reg(tvp_pkg::CSR_ACCEL_RATE, accel_set[ph]);
         write_reg(tvp_pkg::CSR_TIME_STEP, step_set[ph]);
         for (int k = 0; k < 4; k++) begin
            send_idle_pct  = idle_set[k];
            recv_stall_pct = stall_set[k];
            random_moves(48);
         end
         if (ph == 1) begin
            hold_trigger++;
            random_moves(10);
         end
         drain();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain();
      repeat (200) @(posedge clock);

      $display("sent %0d transactions over 5 register settings", items_sent);
      $display("saw %0d triangle points and %0d completed profiles",
               triangle_points, last_points);
      if (mismatches == 0 && points_pending == 0) begin
         $display("trapezoid_velocity_profile_core verification clean");
      end else begin
         $display("trapezoid_velocity_profile_core verification failed");
      end
      $finish;
   end

endmodule
